// ===== hw/rtl/c8sfr_pkg.sv =====
// Shared types, constants and the CRC-8 step for the framed serial receiver.
package c8sfr_pkg;

    // Hunt phases
    localparam logic [1:0] PH_SEEK_AA = 2'd0;
    localparam logic [1:0] PH_SEEK_CC = 2'd1;
    localparam logic [1:0] PH_COLLECT = 2'd2;

    // Framing bytes
    localparam logic [7:0] HDR_BYTE0 = 8'hAA;
    localparam logic [7:0] HDR_BYTE1 = 8'hCC;
    localparam logic [7:0] TERM_LF   = 8'h0A;
    localparam logic [7:0] TERM_CR   = 8'h0D;
    localparam logic [7:0] CRC_POLY  = 8'h07;

    // Command characters
    localparam logic [7:0] CH_W = 8'h57;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_R = 8'h52;

    // Frame offsets
    localparam int HDR_LEN        = 2;
    localparam int OFF_LEN_LO     = 2;
    localparam int OFF_LEN_HI     = 3;
    localparam int OFF_CRC_FIRST  = 4;
    localparam int OFF_TERM_MIN   = 5;
    localparam int OFF_CMD        = 6;
    localparam int OFF_TYP        = 7;
    localparam int OFF_PAY_FIRST  = 8;
    localparam int PAY_BYTES      = 8;
    localparam int PAY_WORD_LO    = 2;
    localparam int PAY_WORD_HI    = 3;
    localparam logic [15:0] LEN_MIN = 16'd8;

    // Offset field width covers the largest supported frame (64 bytes)
    localparam int OFF_W = 6;

    // Result kinds
    localparam logic [2:0] KIND_ODOM     = 3'd0;
    localparam logic [2:0] KIND_GYRO     = 3'd1;
    localparam logic [2:0] KIND_MAG      = 3'd2;
    localparam logic [2:0] KIND_SPEED    = 3'd3;
    localparam logic [2:0] KIND_UNKNOWN  = 3'd4;
    localparam logic [2:0] KIND_CRC_ERR  = 3'd5;
    localparam logic [2:0] KIND_LEN_ERR  = 3'd6;
    localparam logic [2:0] KIND_OVERLONG = 3'd7;

    localparam int DATA_W = 136;

    // Summary of a finished frame handed from the collector to the decoder
    typedef struct packed {
        logic             overlong;
        logic             len_bad;
        logic             crc_bad;
        logic [7:0]       cmd;
        logic [7:0]       typ;
        logic [OFF_W-1:0] term_off;
    } frame_sum_t;

    // One byte of CRC-8, MSB first, no reflection
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        int         k;
        c = crc ^ b;
        for (k = 0; k < 8; k++) begin
            c = {c[6:0], 1'b0} ^ (c[7] ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/c8sfr_frame_mem.sv =====
// Frame byte store: 32-bit words with byte-lane writes, two registered read ports.
module c8sfr_frame_mem #(
    parameter int WORDS = 8,
    parameter int AW    = 3
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [1:0]    wr_lane,
    input  logic [7:0]    wr_byte,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output logic [31:0]   rd_data_a,
    output logic [31:0]   rd_data_b
);

    logic [31:0] store_mem [WORDS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr][{wr_lane, 3'b000} +: 8] <= wr_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a <= store_mem[rd_addr_a];
            rd_data_b <= store_mem[rd_addr_b];
        end
    end

endmodule

// ===== hw/rtl/c8sfr_collect.sv =====
// Header hunt, frame collection, running CRC and length/command capture.
module c8sfr_collect
    import c8sfr_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 31,
    parameter int LEN_LIMIT       = 31,
    parameter int AW              = 3
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_fire,
    input  logic [7:0]    rx_byte,
    output logic          mem_wr_en,
    output logic [AW-1:0] mem_wr_addr,
    output logic [1:0]    mem_wr_lane,
    output logic [7:0]    mem_wr_byte,
    output logic          ev_valid,
    output frame_sum_t    ev_sum
);

    localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [CW-1:0] CntMax = CW'(MAX_FRAME_BYTES);
    localparam logic [15:0]   LenMax = 16'(LEN_LIMIT);

    logic [1:0]    phase_reg, phase_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    prev1_reg, prev1_next;
    logic [7:0]    prev2_reg, prev2_next;
    logic [7:0]    crc_reg, crc_next;
    logic [7:0]    len_lo_reg, len_lo_next;
    logic [7:0]    len_hi_reg, len_hi_next;
    logic [7:0]    cmd_reg, cmd_next;
    logic [7:0]    typ_reg, typ_next;

    logic          is_term;
    logic [15:0]   len_val;
    logic [15:0]   n_val;

    assign len_val     = {len_hi_reg, len_lo_reg};
    assign n_val       = 16'(count_reg) + 16'd1;
    assign is_term     = (count_reg >= CW'(OFF_TERM_MIN)) && (rx_byte == TERM_CR)
                         && (prev1_reg == TERM_LF);
    assign mem_wr_addr = AW'(count_reg[CW-1:2]);
    assign mem_wr_lane = count_reg[1:0];
    assign mem_wr_byte = rx_byte;

    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        prev1_next  = prev1_reg;
        prev2_next  = prev2_reg;
        crc_next    = crc_reg;
        len_lo_next = len_lo_reg;
        len_hi_next = len_hi_reg;
        cmd_next    = cmd_reg;
        typ_next    = typ_reg;
        mem_wr_en   = 1'b0;
        ev_valid    = 1'b0;

        ev_sum.overlong = 1'b0;
        ev_sum.len_bad  = (len_val < LEN_MIN) || (len_val > LenMax) || (len_val != n_val);
        // CRC covers offsets 4 .. n-4; its check byte (n-3) is two bytes back
        ev_sum.crc_bad  = (crc_reg != prev2_reg);
        ev_sum.cmd      = (count_reg == CW'(OFF_CMD)) ? rx_byte : cmd_reg;
        ev_sum.typ      = (count_reg == CW'(OFF_TYP)) ? rx_byte : typ_reg;
        ev_sum.term_off = OFF_W'(count_reg);

        if (in_fire) begin
            prev1_next = rx_byte;
            prev2_next = prev1_reg;
            case (phase_reg)
                PH_COLLECT: begin
                    if (count_reg >= CntMax) begin
                        ev_valid        = 1'b1;
                        ev_sum.overlong = 1'b1;
                        phase_next      = PH_SEEK_AA;
                        count_next      = '0;
                    end else begin
                        mem_wr_en  = 1'b1;
                        count_next = count_reg + CW'(1);
                        if (count_reg == CW'(OFF_LEN_LO)) len_lo_next = rx_byte;
                        if (count_reg == CW'(OFF_LEN_HI)) len_hi_next = rx_byte;
                        if (count_reg == CW'(OFF_CMD))    cmd_next    = rx_byte;
                        if (count_reg == CW'(OFF_TYP))    typ_next    = rx_byte;
                        // fold in the byte two positions back once it is past offset 3
                        if (count_reg >= CW'(OFF_CRC_FIRST + 2)) begin
                            crc_next = crc8_byte(crc_reg, prev2_reg);
                        end
                        if (is_term) begin
                            ev_valid   = 1'b1;
                            phase_next = PH_SEEK_AA;
                            count_next = '0;
                        end
                    end
                end
                PH_SEEK_CC: begin
                    if (rx_byte == HDR_BYTE1) begin
                        phase_next = PH_COLLECT;
                        count_next = CW'(HDR_LEN);
                        crc_next   = 8'h00;
                    end else if (rx_byte != HDR_BYTE0) begin
                        phase_next = PH_SEEK_AA;
                    end
                end
                PH_SEEK_AA: begin
                    phase_next = (rx_byte == HDR_BYTE0) ? PH_SEEK_CC : PH_SEEK_AA;
                    count_next = '0;
                end
                default: begin
                    phase_next = PH_SEEK_AA;
                    count_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SEEK_AA;
            count_reg <= '0;
            prev1_reg <= 8'h00;
            prev2_reg <= 8'h00;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            prev1_reg <= prev1_next;
            prev2_reg <= prev2_next;
        end
    end

    always_ff @(posedge aclk) begin
        crc_reg    <= crc_next;
        len_lo_reg <= len_lo_next;
        len_hi_reg <= len_hi_next;
        cmd_reg    <= cmd_next;
        typ_reg    <= typ_next;
    end

    a_collect_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_COLLECT |-> count_reg >= CW'(HDR_LEN) && count_reg <= CntMax)
        else $error("collect count out of range");

    a_event_rehunt: assert property (@(posedge aclk) disable iff (!aresetn)
        ev_valid |=> phase_reg == PH_SEEK_AA && count_reg == '0)
        else $error("hunt not restarted after frame event");

endmodule

// ===== hw/rtl/c8sfr_decode.sv =====
// Frame decode stage, held gyro/speed values and the result output register.
module c8sfr_decode
    import c8sfr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ev_valid,
    input  frame_sum_t        ev_sum,
    input  logic [31:0]       pay_lo,
    input  logic [31:0]       pay_hi,
    output logic              stage_ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,
    output logic [2:0]        m_tuser
);

    logic              p_valid_reg, p_valid_next;
    frame_sum_t        p_sum_reg;
    logic [15:0]       gyro_reg, gyro_next;
    logic [15:0]       lspd_reg, lspd_next;
    logic [15:0]       rspd_reg, rspd_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [2:0]        kind_reg;
    logic [DATA_W-1:0] data_reg;

    logic              adv;
    logic              load;
    logic [63:0]       pay_word;
    logic [7:0]        pb [PAY_BYTES];
    logic [2:0]        kind;
    logic [31:0]       left_dist;
    logic [31:0]       right_dist;
    logic [15:0]       compass_deg;
    logic [7:0]        compass_stat;

    assign adv         = !m_tvalid_reg || m_tready;
    assign load        = p_valid_reg && adv;
    assign stage_ready = !p_valid_reg || adv;
    assign pay_word    = {pay_hi, pay_lo};

    // Payload bytes: the terminator is written the same cycle the words are read,
    // so it is forwarded; bytes past the end of the frame read as zero.
    always_comb begin
        for (int k = 0; k < PAY_BYTES; k++) begin
            if (OFF_W'(OFF_PAY_FIRST + k) == p_sum_reg.term_off) begin
                pb[k] = TERM_CR;
            end else if (OFF_W'(OFF_PAY_FIRST + k) > p_sum_reg.term_off) begin
                pb[k] = 8'h00;
            end else begin
                pb[k] = pay_word[8*k +: 8];
            end
        end
    end

    always_comb begin
        gyro_next    = gyro_reg;
        lspd_next    = lspd_reg;
        rspd_next    = rspd_reg;
        left_dist    = 32'h0;
        right_dist   = 32'h0;
        compass_deg  = 16'h0;
        compass_stat = 8'h00;
        if (p_sum_reg.overlong) begin
            kind = KIND_OVERLONG;
        end else if (p_sum_reg.len_bad) begin
            kind = KIND_LEN_ERR;
        end else if (p_sum_reg.crc_bad) begin
            kind = KIND_CRC_ERR;
        end else if (p_sum_reg.cmd == CH_W && p_sum_reg.typ == CH_E) begin
            kind       = KIND_ODOM;
            left_dist  = {pb[3], pb[2], pb[1], pb[0]};
            right_dist = {pb[7], pb[6], pb[5], pb[4]};
        end else if (p_sum_reg.cmd == CH_G && p_sum_reg.typ == CH_B) begin
            kind      = KIND_GYRO;
            gyro_next = {pb[1], pb[0]};
        end else if (p_sum_reg.cmd == CH_E && p_sum_reg.typ == CH_A) begin
            kind         = KIND_MAG;
            compass_deg  = {pb[1], pb[0]};
            compass_stat = pb[2];
        end else if (p_sum_reg.cmd == CH_W && p_sum_reg.typ == CH_R) begin
            kind      = KIND_SPEED;
            rspd_next = {pb[1], pb[0]};
            lspd_next = {pb[3], pb[2]};
        end else begin
            kind = KIND_UNKNOWN;
        end
    end

    always_comb begin
        p_valid_next  = p_valid_reg;
        m_tvalid_next = m_tvalid_reg;
        if (adv) begin
            m_tvalid_next = p_valid_reg;
            p_valid_next  = 1'b0;
        end
        if (ev_valid) begin
            p_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            gyro_reg     <= 16'h0;
            lspd_reg     <= 16'h0;
            rspd_reg     <= 16'h0;
        end else begin
            p_valid_reg  <= p_valid_next;
            m_tvalid_reg <= m_tvalid_next;
            if (load) begin
                gyro_reg <= gyro_next;
                lspd_reg <= lspd_next;
                rspd_reg <= rspd_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ev_valid) begin
            p_sum_reg <= ev_sum;
        end
        if (load) begin
            kind_reg <= kind;
            data_reg <= {compass_stat, compass_deg, rspd_next, lspd_next, gyro_next,
                         right_dist, left_dist};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = kind_reg;

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !stage_ready |-> p_valid_reg && m_tvalid_reg && !m_tready)
        else $error("input stalled without a blocked result");

    a_held_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !load |=> $stable(gyro_reg) && $stable(lspd_reg) && $stable(rspd_reg))
        else $error("held values changed without a result");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        ev_valid |-> stage_ready)
        else $error("frame event while decode stage blocked");

endmodule

// ===== hw/rtl/crc8_serial_frame_receiver_core.sv =====
// Top level of the CRC-8 framed serial receiver: collector, frame store, decoder.
// Throughput: one received byte per cycle; s_tready drops only while a result
//   sits in the decode stage and the output register is held by m_tready low.
// Result path: the edge that accepts the terminating (or overflowing) byte
//   captures the frame summary and the frame store read; a later edge, once the
//   output register is free, decodes into it and raises m_tvalid.
// Reset (aresetn low, synchronous): hunt restarts at the first header byte, the
//   byte count and the held gyro/speed values clear; the frame store is not cleared.
module crc8_serial_frame_receiver_core
    import c8sfr_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 31,
    parameter int LEN_LIMIT       = 31
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] rx_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    // [31:0] left_distance, [63:32] right_distance, [79:64] heading,
    // [95:80] left_wheel_speed, [111:96] right_wheel_speed,
    // [127:112] compass_degrees, [135:128] compass_status
    output logic [DATA_W-1:0] m_tdata,
    output logic [2:0]        m_tuser    // [2:0] kind
);

    // Frame store words; at least four so the payload words (offsets 8..15) exist
    localparam int NeedWords = (MAX_FRAME_BYTES + 3) / 4;
    localparam int MemWords  = (NeedWords < 4) ? 4 : NeedWords;
    localparam int AW        = $clog2(MemWords);

    logic          in_fire;
    logic          stage_ready;
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [1:0]    mem_wr_lane;
    logic [7:0]    mem_wr_byte;
    logic          ev_valid;
    frame_sum_t    ev_sum;
    logic [31:0]   pay_lo;
    logic [31:0]   pay_hi;

    assign s_tready = stage_ready;
    assign in_fire  = s_tvalid && s_tready;

    // Hunt/collect: writes each frame byte into the store, tracks CRC and fields
    c8sfr_collect #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .LEN_LIMIT       (LEN_LIMIT),
        .AW              (AW)
    ) u_collect (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .rx_byte     (s_tdata),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_lane (mem_wr_lane),
        .mem_wr_byte (mem_wr_byte),
        .ev_valid    (ev_valid),
        .ev_sum      (ev_sum)
    );

    // Payload words are fetched on the frame event; decode sees them next cycle
    c8sfr_frame_mem #(
        .WORDS (MemWords),
        .AW    (AW)
    ) u_frame_mem (
        .aclk      (aclk),
        .wr_en     (mem_wr_en),
        .wr_addr   (mem_wr_addr),
        .wr_lane   (mem_wr_lane),
        .wr_byte   (mem_wr_byte),
        .rd_en     (ev_valid),
        .rd_addr_a (AW'(PAY_WORD_LO)),
        .rd_addr_b (AW'(PAY_WORD_HI)),
        .rd_data_a (pay_lo),
        .rd_data_b (pay_hi)
    );

    // Kind selection, held-value update and output register
    c8sfr_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ev_valid    (ev_valid),
        .ev_sum      (ev_sum),
        .pay_lo      (pay_lo),
        .pay_hi      (pay_hi),
        .stage_ready (stage_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule
